@@ hdl/pulse_channel_with_sweep_assert.svh @@
// Assertion macros for the pulse channel block.
`ifndef PULSE_CHANNEL_WITH_SWEEP_ASSERT_SVH
`define PULSE_CHANNEL_WITH_SWEEP_ASSERT_SVH

`ifndef SYNTH

// Clocked property, disabled during reset.
`define PCSW_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcsw check failed");

// Clocked property, checked during reset too.
`define PCSW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pcsw check failed");

`else

`define PCSW_ASSERT(name, clk, rst, prop)
`define PCSW_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ hdl/pcsw_pkg.sv @@
// Package: beat types, op and register codes, duty patterns.
`default_nettype none

package pcsw_pkg;

  // Item kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Channel register offsets
  localparam logic [2:0] REG_SWEEP  = 3'd0;
  localparam logic [2:0] REG_DUTY   = 3'd1;
  localparam logic [2:0] REG_ENV    = 3'd2;
  localparam logic [2:0] REG_PER_LO = 3'd3;
  localparam logic [2:0] REG_PER_HI = 3'd4;

  localparam logic [7:0] READ_OPEN_BUS = 8'hFF;

  // Duty patterns, bit n is step n of the pattern
  localparam logic [7:0] DUTY_PATTERN [4] = '{
    8'b0111_1111,
    8'b0111_1110,
    8'b0001_1110,
    8'b1000_0001
  };

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic       div_bit4;
    logic       channel_step;
  } item_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] level;
    logic       channel_active;
  } result_beat_t;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    pat = DUTY_PATTERN[sel];
    return pat[pos];
  endfunction

endpackage

`default_nettype wire

@@ hdl/pcsw_item_if.sv @@
// Input channel: valid/ready with one item beat.
`default_nettype none

interface pcsw_item_if import pcsw_pkg::*; ();
  logic       valid;
  logic       ready;
  item_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/pcsw_result_if.sv @@
// Output channel: valid/ready with one result beat.
`default_nettype none

interface pcsw_result_if import pcsw_pkg::*; ();
  logic         valid;
  logic         ready;
  result_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/pulse_channel_with_sweep.sv @@
// Latency: a result beat is valid the cycle after its item beat is accepted.
// Throughput: one item per cycle while each result is taken; all channel state updates
// in the accept cycle, and no new item is let in while a result waits untaken.
// Reset (rst, synchronous): all channel state, power and result valid go to zero.
// No clearing pass; the block takes items from the first cycle after reset.
`default_nettype none

module pulse_channel_with_sweep import pcsw_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  pcsw_item_if.sink   item,
  pcsw_result_if.source result,
  input  wire logic   cfg_we,
  input  wire logic   cfg_data
);

`include "pulse_channel_with_sweep_assert.svh"

  // Channel state
  logic        apu_power;
  logic [7:0]  reg_sweep, reg_duty, reg_env, reg_per_lo, reg_per_hi;
  logic        channel_on;
  logic        last_div_bit;
  logic [2:0]  sequencer_step;
  logic [2:0]  duty_position;
  logic [11:0] period_count;
  logic [3:0]  volume;
  logic [2:0]  sweep_count;
  logic [2:0]  sweep_pace_latched;
  logic        env_up;
  logic [2:0]  env_pace_latched;
  logic [2:0]  env_count;
  logic [6:0]  length_count;
  logic [3:0]  level_held;

  logic [7:0]  reg_sweep_next, reg_duty_next, reg_env_next, reg_per_lo_next, reg_per_hi_next;
  logic        channel_on_next;
  logic        last_div_bit_next;
  logic [2:0]  sequencer_step_next;
  logic [2:0]  duty_position_next;
  logic [11:0] period_count_next;
  logic [3:0]  volume_next;
  logic [2:0]  sweep_count_next;
  logic [2:0]  sweep_pace_latched_next;
  logic        env_up_next;
  logic [2:0]  env_pace_latched_next;
  logic [2:0]  env_count_next;
  logic [6:0]  length_count_next;
  logic [3:0]  level_held_next;
  logic [7:0]  read_data_next;

  logic         accept;
  logic         result_valid;
  result_beat_t result_beat;
  item_beat_t   in_beat;

  assign in_beat    = item.data;
  assign accept     = item.valid && item.ready;
  assign item.ready = !result_valid || result.ready;

  // Next-state logic for one item
  always_comb begin
    logic        fall;
    logic [2:0]  pace;
    logic [10:0] per;
    logic [10:0] delta;
    logic [11:0] new_per;
    logic [7:0]  wdata;

    reg_sweep_next          = reg_sweep;
    reg_duty_next           = reg_duty;
    reg_env_next            = reg_env;
    reg_per_lo_next         = reg_per_lo;
    reg_per_hi_next         = reg_per_hi;
    channel_on_next         = channel_on;
    last_div_bit_next       = last_div_bit;
    sequencer_step_next     = sequencer_step;
    duty_position_next      = duty_position;
    period_count_next       = period_count;
    volume_next             = volume;
    sweep_count_next        = sweep_count;
    sweep_pace_latched_next = sweep_pace_latched;
    env_up_next             = env_up;
    env_pace_latched_next   = env_pace_latched;
    env_count_next          = env_count;
    length_count_next       = length_count;
    level_held_next         = level_held;
    read_data_next          = 8'h00;

    fall    = last_div_bit && !in_beat.div_bit4;
    pace    = reg_sweep[6:4];
    per     = {reg_per_hi[2:0], reg_per_lo};
    delta   = per >> reg_sweep[2:0];
    new_per = reg_sweep[3] ? ({1'b0, per} - {1'b0, delta}) : ({1'b0, per} + {1'b0, delta});
    wdata   = in_beat.write_data;

    if (in_beat.op == OP_TICK) begin
      if (apu_power) begin
        // Frame sequencer on a falling edge of the divider bit
        if (fall) begin
          sequencer_step_next = sequencer_step + 3'd1;
          // Length timer on even steps
          if (!sequencer_step_next[0] && channel_on_next && reg_per_hi[6]) begin
            length_count_next = length_count + 7'd1;
            if (length_count_next[6]) begin
              channel_on_next = 1'b0;
            end
          end
          // Sweep every fourth step
          if (sequencer_step_next[1:0] == 2'd0 && channel_on_next && pace != 3'd0) begin
            sweep_count_next = sweep_count + 3'd1;
            if (sweep_count_next == sweep_pace_latched) begin
              if (new_per[11] || new_per == 12'd0) begin
                channel_on_next = 1'b0;
              end else begin
                reg_per_lo_next = new_per[7:0];
                reg_per_hi_next = {reg_per_hi[7:3], new_per[10:8]};
              end
              sweep_count_next        = 3'd0;
              sweep_pace_latched_next = pace;
            end
          end
          // Envelope every eighth step
          if (sequencer_step_next == 3'd0 && channel_on_next && env_pace_latched != 3'd0) begin
            env_count_next = env_count + 3'd1;
            if (env_count_next >= env_pace_latched) begin
              if (env_up) begin
                if (volume != 4'd15) volume_next = volume + 4'd1;
              end else begin
                if (volume != 4'd0) volume_next = volume - 4'd1;
              end
              env_count_next = 3'd0;
            end
          end
        end
        last_div_bit_next = in_beat.div_bit4;
        // Channel clock: period counter and duty stepping
        if (in_beat.channel_step && channel_on_next) begin
          if (reg_env[7:3] == 5'd0) begin
            channel_on_next = 1'b0;
          end else begin
            period_count_next = period_count + 12'd1;
            if (period_count_next[11]) begin
              duty_position_next = duty_position + 3'd1;
              period_count_next  = {1'b0, reg_per_hi_next[2:0], reg_per_lo_next};
            end
            level_held_next = duty_bit(reg_duty[7:6], duty_position_next) ? volume_next : 4'd0;
          end
        end
      end
    end else if (in_beat.op == OP_WRITE) begin
      if (!apu_power) begin
        if (in_beat.reg_offset == REG_DUTY) reg_duty_next = wdata;
      end else begin
        unique case (in_beat.reg_offset)
          REG_SWEEP: begin
            // Sweep restarts when the pace goes from zero to nonzero
            if (reg_sweep[6:4] == 3'd0 && wdata[6:4] != 3'd0) begin
              sweep_count_next        = 3'd0;
              sweep_pace_latched_next = wdata[6:4];
            end
            reg_sweep_next = wdata;
          end
          REG_DUTY:   reg_duty_next   = wdata;
          REG_ENV:    reg_env_next    = wdata;
          REG_PER_LO: reg_per_lo_next = wdata;
          REG_PER_HI: begin
            if (wdata[7]) begin
              // Trigger: reload from the period that includes the new high bits
              reg_per_hi_next         = {1'b0, wdata[6:0]};
              channel_on_next         = 1'b1;
              duty_position_next      = 3'd0;
              volume_next             = reg_env[7:4];
              period_count_next       = {1'b0, wdata[2:0], reg_per_lo};
              sweep_count_next        = 3'd0;
              sweep_pace_latched_next = pace;
              env_up_next             = reg_env[3];
              env_pace_latched_next   = reg_env[2:0];
              env_count_next          = 3'd0;
              length_count_next       = {1'b0, reg_duty[5:0]};
            end else begin
              reg_per_hi_next = wdata;
            end
          end
          default: ;
        endcase
      end
    end else if (in_beat.op == OP_READ) begin
      unique case (in_beat.reg_offset)
        REG_SWEEP:  read_data_next = reg_sweep;
        REG_DUTY:   read_data_next = reg_duty & 8'hC0;
        REG_ENV:    read_data_next = reg_env;
        REG_PER_LO: read_data_next = reg_per_lo;
        REG_PER_HI: read_data_next = reg_per_hi & 8'h40;
        default:    read_data_next = READ_OPEN_BUS;
      endcase
    end
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_sweep          <= '0;
      reg_duty           <= '0;
      reg_env            <= '0;
      reg_per_lo         <= '0;
      reg_per_hi         <= '0;
      channel_on         <= 1'b0;
      last_div_bit       <= 1'b0;
      sequencer_step     <= '0;
      duty_position      <= '0;
      period_count       <= '0;
      volume             <= '0;
      sweep_count        <= '0;
      sweep_pace_latched <= '0;
      env_up             <= 1'b0;
      env_pace_latched   <= '0;
      env_count          <= '0;
      length_count       <= '0;
      level_held         <= '0;
    end else if (accept) begin
      reg_sweep          <= reg_sweep_next;
      reg_duty           <= reg_duty_next;
      reg_env            <= reg_env_next;
      reg_per_lo         <= reg_per_lo_next;
      reg_per_hi         <= reg_per_hi_next;
      channel_on         <= channel_on_next;
      last_div_bit       <= last_div_bit_next;
      sequencer_step     <= sequencer_step_next;
      duty_position      <= duty_position_next;
      period_count       <= period_count_next;
      volume             <= volume_next;
      sweep_count        <= sweep_count_next;
      sweep_pace_latched <= sweep_pace_latched_next;
      env_up             <= env_up_next;
      env_pace_latched   <= env_pace_latched_next;
      env_count          <= env_count_next;
      length_count       <= length_count_next;
      level_held         <= level_held_next;
    end
  end

  // Power register
  always_ff @(posedge clk) begin
    if (rst) begin
      apu_power <= 1'b0;
    end else if (cfg_we) begin
      apu_power <= cfg_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item.ready) begin
      result_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_beat.read_data      <= read_data_next;
      result_beat.level          <= level_held_next;
      result_beat.channel_active <= channel_on_next;
    end
  end

  assign result.valid = result_valid;
  assign result.data  = result_beat;

  // Beat classes and frame state watched by the checks
  logic       trig_beat;
  logic       idle_tick_beat;
  logic [4:0] frame_state;

  assign trig_beat      = accept && apu_power && in_beat.op == OP_WRITE &&
                          in_beat.reg_offset == REG_PER_HI && in_beat.write_data[7];
  assign idle_tick_beat = accept && !apu_power && in_beat.op == OP_TICK;
  assign frame_state    = {sequencer_step, last_div_bit, channel_on};

  // Checks
  `PCSW_ASSERT(a_on_by_trigger, clk, rst, $rose(channel_on) |-> $past(trig_beat))
  `PCSW_ASSERT(a_power_off_tick, clk, rst, idle_tick_beat |=> $stable(frame_state))
  `PCSW_ASSERT(a_length_in_range, clk, rst, channel_on |-> !length_count[6])
  `PCSW_ASSERT(a_level_hold, clk, rst, !accept |=> $stable(level_held))
  `PCSW_ASSERT_ALWAYS(a_ready_stall, clk, !item.ready |-> (result_valid && !result.ready))

endmodule

`default_nettype wire
